>>> src/atr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the average true range block.
// No dependencies; imported by the top level, the divider and the testbench.
package atr_pkg;

  localparam int MAX_PERIOD   = 256;
  localparam int PERIOD_RESET = 14;
  localparam int PRICE_W      = 32;
  localparam int SUM_W        = 40;
  localparam int PERIOD_W     = 9;
  localparam int CNT_W        = $clog2(MAX_PERIOD + 1);
  localparam int DIV_CNT_W    = $clog2(SUM_W);

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> src/average_true_range.sv
`timescale 1ns / 1ps
// A bar that yields a result raises out_tvalid once the 40-step bit-serial divider is done;
// the block takes a new bar only once it is through with the last one (in_tready only in
// ST_IDLE), and a stalled result holds the next result in the final state (ST_FIN).
// Reset (rst_n low, synchronous): period 14; prev close, sum, count, average and result cleared.
// Top level: sequencer for true range, warm-up sum, Wilder update. Uses atr_pkg, atr_div.
module average_true_range (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: smoothing_period
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  // input bars
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // high_price [31:0], low_price [63:32], close_price [95:64]
  input  logic        in_tuser,   // series_start
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // atr_value [31:0]
);
  import atr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HL, ST_HC, ST_LC, ST_UPD, ST_CHK, ST_DIV, ST_FIN
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     period_r;
  logic [PRICE_W-1:0]   hi_r, lo_r, cl_r;
  logic                 start_r;
  logic                 first_r;
  logic                 steady_r;
  logic                 neg_r;
  logic [PRICE_W-1:0]   prev_close_r;
  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     bars_r;
  logic [PRICE_W-1:0]   avg_r;
  logic [PRICE_W-1:0]   tr_r;
  logic [SUM_W-1:0]     dvd_r;
  logic                 div_start_r;
  logic                 out_valid_r;
  logic [PRICE_W-1:0]   out_data_r;

  logic [SUM_W-1:0]     quotient;
  div_sts_t             div_sts;

  // Shared-path datapath terms, one subtract per state.
  logic [PRICE_W:0]     hl_diff;
  logic [PRICE_W:0]     pc_diff;
  logic [PRICE_W-1:0]   pc_abs;
  logic [PRICE_W:0]     avg_diff;
  logic [PRICE_W-1:0]   avg_mag;
  logic [PRICE_W-1:0]   q_lo;
  logic [PRICE_W-1:0]   avg_new;
  logic                 out_free;

  always_comb begin
    hl_diff  = {1'b0, hi_r} - {1'b0, lo_r};
    // high against previous close in HC, low against it in LC
    pc_diff  = (state_r == ST_HC) ? ({1'b0, hi_r} - {1'b0, prev_close_r})
                                  : ({1'b0, lo_r} - {1'b0, prev_close_r});
    pc_abs   = pc_diff[PRICE_W] ? (~pc_diff[PRICE_W-1:0] + PRICE_W'(1))
                                : pc_diff[PRICE_W-1:0];
    avg_diff = {1'b0, tr_r} - {1'b0, avg_r};
    avg_mag  = avg_diff[PRICE_W] ? (~avg_diff[PRICE_W-1:0] + PRICE_W'(1))
                                 : avg_diff[PRICE_W-1:0];
    q_lo     = quotient[PRICE_W-1:0];
    // avg += trunc(diff / P), modulo 2^32
    avg_new  = neg_r ? (avg_r - q_lo) : (avg_r + q_lo);
    out_free = !out_valid_r || out_tready;
  end

  atr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dvd_r),
    .divisor  (period_r),
    .quotient (quotient),
    .sts      (div_sts)
  );

  // Period register: clamp to 1..MAX_PERIOD as it is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= CNT_W'(PERIOD_RESET);
    end else if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        period_r <= CNT_W'(1);
      end else if (32'(cfg_wr_data) > 32'(MAX_PERIOD)) begin
        period_r <= CNT_W'(MAX_PERIOD);
      end else begin
        period_r <= CNT_W'(cfg_wr_data);
      end
    end
  end

  // Sequencer with its registered outputs and bar state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prev_close_r <= '0;
      sum_r        <= '0;
      bars_r       <= '0;
      avg_r        <= '0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // launch the divider when the check state finds a division to do
      div_start_r <= (state_r == ST_CHK) && (steady_r || (bars_r >= period_r));
      // drop the result once the consumer takes it; the final state loads the next one
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_HL;
          end
        end
        ST_HL: begin
          // high minus low, clamped at zero; later maxima are never negative
          tr_r    <= hl_diff[PRICE_W] ? '0 : hl_diff[PRICE_W-1:0];
          first_r <= start_r || (bars_r == '0);
          state_r <= (start_r || (bars_r == '0)) ? ST_UPD : ST_HC;
        end
        ST_HC: begin
          if (pc_abs > tr_r) tr_r <= pc_abs;
          state_r <= ST_LC;
        end
        ST_LC: begin
          if (pc_abs > tr_r) tr_r <= pc_abs;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          prev_close_r <= cl_r;
          if (first_r) begin
            sum_r    <= SUM_W'(tr_r);
            bars_r   <= CNT_W'(1);
            steady_r <= 1'b0;
          end else if (bars_r < CNT_W'(MAX_PERIOD) && bars_r < period_r) begin
            sum_r    <= sum_r + SUM_W'(tr_r);
            bars_r   <= bars_r + CNT_W'(1);
            steady_r <= 1'b0;
          end else begin
            steady_r <= 1'b1;
            neg_r    <= avg_diff[PRICE_W];
            dvd_r    <= SUM_W'(avg_mag);
          end
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (steady_r) begin
            state_r <= ST_DIV;
          end else if (bars_r >= period_r) begin
            dvd_r   <= sum_r;
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_sts.done && !div_sts.busy) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold here while an older result still waits for its transfer
          if (out_free) begin
            if (steady_r) begin
              avg_r      <= avg_new;
              out_data_r <= avg_new;
            end else begin
              avg_r      <= q_lo;
              out_data_r <= q_lo;
              bars_r     <= CNT_W'(MAX_PERIOD);
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the bar on its transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hi_r    <= in_tdata[31:0];
      lo_r    <= in_tdata[63:32];
      cl_r    <= in_tdata[95:64];
      start_r <= in_tuser;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/atr_div.sv
`timescale 1ns / 1ps
// Restoring bit-serial divider: one quotient bit per cycle, SUM_W steps.
// Depends on atr_pkg.
module atr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [atr_pkg::SUM_W-1:0]    dividend,
  input  logic [atr_pkg::CNT_W-1:0]    divisor,
  output logic [atr_pkg::SUM_W-1:0]    quotient,
  output atr_pkg::div_sts_t            sts
);
  import atr_pkg::*;

  logic [SUM_W-1:0]     q_r, q_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;
  logic [CNT_W:0]       rem_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem_r, q_r[SUM_W-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
    rem_nxt = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    q_nxt   = {q_r[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse done together with the last step
      done_r <= !start && busy_r && (cnt_r == DIV_CNT_W'(SUM_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> src/atr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for average_true_range, attached by bind.
// Depends only on the top level's ports.
module atr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // after a bar transfer the block is busy on it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after a bar transfer");

  // no result can appear the cycle after a bar is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after a bar transfer");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("block not idle after reset");

endmodule

bind average_true_range atr_checker u_atr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb_average_true_range.sv
`timescale 1ns / 1ps
// Self-checking testbench for average_true_range: drives price bars and period writes,
// predicts every ATR result with a scoreboard class. Depends on atr_pkg and the block.
module tb_average_true_range;
  import atr_pkg::*;

  // No-transfer cycles tolerated before the run is declared hung. Covers the longest
  // sender gap, the full divider latency, the longest receiver stall and a config pause.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Cycles a bar may still occupy the block after the last expected result.
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned TARGET_BARS    = 1200;
  localparam longint      PRICE_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam longint      SWING          = 64'd1 << 20;  // 16.0 in Q16.16

  // Wilder ATR predictor with its own copy of the period register and price state.
  class atr_scoreboard;
    logic [8:0]  period_reg;
    logic [31:0] last_close;
    logic [39:0] tr_sum;
    int unsigned warm_count;
    logic [31:0] atr_avg;
    logic [31:0] atr_expected[$];
    int unsigned mismatches;

    function new();
      period_reg = 9'(PERIOD_RESET);
      last_close = '0;
      tr_sum     = '0;
      warm_count = 0;
      atr_avg    = '0;
      mismatches = 0;
    endfunction

    function void set_period(logic [8:0] value);
      period_reg = value;
    endfunction

    function bit pending();
      return atr_expected.size() != 0;
    endfunction

    // Advance the prediction by one accepted bar; queue the ATR it produces, if any.
    function void note_bar(logic [31:0] hi, logic [31:0] lo, logic [31:0] cl, logic st);
      longint      hi_l, lo_l, pc_l, span, tr, dist_hi, dist_lo, avg_l;
      logic [39:0] quot;
      int unsigned p;
      bit          emitted;
      hi_l    = longint'(hi);
      lo_l    = longint'(lo);
      p       = (period_reg == 0) ? 1 : period_reg;
      if (p > MAX_PERIOD) p = MAX_PERIOD;
      span    = hi_l - lo_l;
      emitted = 1'b0;
      if (st || warm_count == 0) begin
        // first bar of a series: no previous close, inverted bar clamps to zero
        tr         = (span < 0) ? 0 : span;
        tr_sum     = tr[39:0];
        warm_count = 1;
      end else begin
        pc_l    = longint'(last_close);
        dist_hi = (hi_l > pc_l) ? hi_l - pc_l : pc_l - hi_l;
        dist_lo = (lo_l > pc_l) ? lo_l - pc_l : pc_l - lo_l;
        tr      = span;
        if (dist_hi > tr) tr = dist_hi;
        if (dist_lo > tr) tr = dist_lo;
        if (warm_count < MAX_PERIOD && warm_count < p) begin
          tr_sum     = tr_sum + tr[39:0];
          warm_count = warm_count + 1;
        end else begin
          // Wilder update, signed division truncating toward zero
          avg_l   = longint'(atr_avg);
          avg_l   = avg_l + (tr - avg_l) / longint'(p);
          atr_avg = avg_l[31:0];
          atr_expected.push_back(atr_avg);
          emitted = 1'b1;
        end
      end
      if (!emitted && warm_count >= p) begin
        quot       = tr_sum / p;
        atr_avg    = quot[31:0];
        warm_count = MAX_PERIOD;
        atr_expected.push_back(atr_avg);
      end
      last_close = cl;
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (atr_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected atr_value %08h", got);
        return;
      end
      want = atr_expected.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("atr_value mismatch: expected %08h, got %08h", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // high_price [31:0], low_price [63:32], close_price [95:64]
  logic        in_tuser;   // series_start
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // atr_value [31:0]

  atr_scoreboard sb = new();
  bit            gaps_on;
  int unsigned   bars_sent;
  int unsigned   idle_cycles;

  // Period settings walked by the random phases: extremes, out-of-range codes and the
  // reset value, then random periods.
  logic [8:0] period_plan [9] = '{9'd1, 9'd14, 9'd0, 9'd256, 9'd511, 9'd3, 9'd300, 9'd2,
                                  9'd255};

  average_true_range uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Present one bar at a falling edge (after an optional gap), hold it until the
  // transfer, and hand it to the predictor. Valid stays up until the next call or drain.
  task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo,
                          input logic [31:0] cl, input logic st);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {cl, lo, hi};
    in_tuser  = st;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_bar(hi, lo, cl, st);
    bars_sent++;
  endtask

  // Drop valid, wait for every expected result, then let a result-free bar finish.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the period register; only called with the block idle.
  task automatic write_period(input logic [8:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_period(value);
  endtask

  // Result side: random stalls on tready, checked at the rising edge.
  initial begin
    int unsigned hold;
    hold       = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!gaps_on || !out_tready) begin
        out_tready = 1'b1;
        hold       = gaps_on ? $urandom_range(0, 30) : 0;
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          out_tready = 1'b0;
          hold--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase, n_bars, p_eff, kind, k;
    logic [8:0]  per;
    logic [31:0] h, l, c;
    logic        st;
    bit          restart;
    longint      px, up, dn;

    bars_sent   = 0;
    gaps_on     = 1'b1;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset period of 14: warm-up starts on its own (no series flag), including a later
    // inverted bar and an all-zero bar.
    send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    drain();
    // Shrink the period mid warm-up: the next bar reaches the count and divides.
    write_period(9'd4);
    send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
    drain();
    // Period code 0 behaves as 1: every bar emits its own true range.
    write_period(9'd0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'h0001_0000, 32'h0002_0000, 32'h0001_8000, 1'b1);  // inverted first bar
    send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_bar(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);
    send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    drain();
    // Period 2: restart the series, then falling true ranges exercise truncation of
    // negative steps toward zero.
    write_period(9'd2);
    send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 1'b1);
    send_bar(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'hFFFF_FFFD, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 1'b0);
    drain();

    // Random phases: one period per phase, written while idle. Large periods restart
    // the series only when a full warm-up is wanted; otherwise they continue steady.
    px    = 64'h0064_0000;
    phase = 0;
    while (bars_sent < TARGET_BARS) begin
      per     = (phase < 9) ? period_plan[phase] : 9'($urandom_range(0, 40));
      p_eff   = (per == 0) ? 1 : ((per > MAX_PERIOD) ? MAX_PERIOD : per);
      restart = (p_eff <= 50) ? 1'($urandom_range(0, 1)) : (per == 9'd256);
      n_bars  = (restart && p_eff > 50) ? p_eff + 30 : $urandom_range(15, 60);
      gaps_on = ($urandom_range(0, 3) != 0);
      write_period(per);
      for (k = 0; k < n_bars; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          // well-formed bar around a wandering price, occasionally jumping level
          if ($urandom_range(0, 49) == 0) px = longint'($urandom);
          px = px + longint'($urandom_range(0, 2 * SWING)) - SWING;
          if (px < 0) px = 0;
          if (px > PRICE_MAX) px = PRICE_MAX;
          up = px + longint'($urandom_range(0, SWING));
          dn = px - longint'($urandom_range(0, SWING));
          if (up > PRICE_MAX) up = PRICE_MAX;
          if (dn < 0) dn = 0;
          h = up[31:0];
          l = dn[31:0];
          c = l + $urandom_range(0, h - l);
        end else if (kind < 87) begin
          h = $urandom;
          l = $urandom;
          c = $urandom;
        end else if (kind < 95) begin
          // inverted bar: low strictly above high
          l = $urandom;
          if (l == 0) l = 1;
          h = $urandom_range(0, l - 1);
          c = $urandom;
        end else begin
          h = {32{1'($urandom_range(0, 1))}};
          l = {32{1'($urandom_range(0, 1))}};
          c = {32{1'($urandom_range(0, 1))}};
        end
        st = (k == 0) ? restart : ($urandom_range(0, 4 * p_eff + 20) == 0);
        send_bar(h, l, c, st);
      end
      drain();
      phase++;
    end

    // Everything received and settled; catch stray results during the settle window.
    if (sb.mismatches == 0 && !sb.pending()) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/atr_pkg.sv
src/atr_div.sv
src/average_true_range.sv
src/atr_checker.sv
tb/tb_average_true_range.sv
